// ----- rtl/core/rkfg_pkg.sv -----
// Shared constants and helper functions for the RGB keyframe fade generator.
package rkfg_pkg;

    // Keyframe field widths.
    localparam int CHAN_W = 8;
    localparam int MODE_W = 2;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;

    // Segments longer than this are clipped when the keyframe is stored.
    localparam logic [LEN_W-1:0] MAX_SEGMENT_LENGTH = 7'd64;

    // Transition modes; the unused code behaves as a plain step.
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINE   = 2'd2;

    // Serial arithmetic unit: operand width and iteration counter.
    localparam int OP_W  = 32;
    localparam int CNT_W = $clog2(OP_W);
    localparam logic [CNT_W-1:0] OP_LAST = CNT_W'(OP_W - 1);
    localparam int DEN_W = 7;

    // Fixed-point constants of the sine-squared weight.
    localparam logic [OP_W-1:0] ANGLE_K = 32'd25723;
    localparam logic [OP_W-1:0] Q30_ONE = 32'h4000_0000;
    localparam int W_W = 17;
    localparam logic [W_W-1:0] W_ONE = 17'h1_0000;

    // Divisors of the Taylor series terms, innermost first.
    localparam logic [DEN_W-1:0] TAYLOR_DIV1 = 7'd72;
    localparam logic [DEN_W-1:0] TAYLOR_DIV2 = 7'd42;
    localparam logic [DEN_W-1:0] TAYLOR_DIV3 = 7'd20;
    localparam logic [DEN_W-1:0] TAYLOR_DIV4 = 7'd6;

    // Blend one channel with a Q1.16 weight: floor(c1 + (c2 - c1) * w / 65536).
    function automatic logic [CHAN_W-1:0] sine_mix(
        input logic [CHAN_W-1:0] c1,
        input logic [CHAN_W-1:0] c2,
        input logic [W_W-1:0]    w
    );
        logic signed [CHAN_W:0] diff;
        logic signed [26:0]     prod;
        logic signed [26:0]     sum;
        diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
        prod = 27'(diff) * 27'($signed({1'b0, w}));
        sum  = prod + 27'($signed({1'b0, c1, 16'h0000}));
        return sum[23:16];
    endfunction

    // Numerator of the linear blend: c1 * len + (c2 - c1) * i, never negative.
    function automatic logic [14:0] lin_num(
        input logic [CHAN_W-1:0] c1,
        input logic [CHAN_W-1:0] c2,
        input logic [IDX_W-1:0]  idx,
        input logic [LEN_W-1:0]  len
    );
        logic signed [CHAN_W:0] diff;
        logic signed [16:0]     sum;
        diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
        sum  = 17'($signed({1'b0, c1})) * 17'($signed({1'b0, len}))
             + 17'(diff) * 17'($signed({1'b0, idx}));
        return sum[14:0];
    endfunction

endpackage

// ----- rtl/core/rgb_keyframe_fade_generator_core.sv -----
// Keyframe fade generator: turns RGB keyframes into per-step faded colors.
//
// Keyframes arrive on the s_ channel; each transaction carries a color, a
// transition mode and a segment length, with start_new on s_tuser. The block
// stores one keyframe. When the next keyframe arrives (and start_new is low),
// it streams the samples of the stored keyframe's segment on the m_ channel,
// one transaction per step, with m_tlast on the final sample of the segment.
// The first keyframe, a start_new keyframe or a stored length of zero
// produces no samples. s_tready is high only while no segment is in work.
// The work per sample depends on the stored mode, and is done by a
// bit-serial shift-add multiplier and a bit-serial restoring divider:
//   none:   no multiplication or division.
//   linear: 3 divisions per sample.
//   sine:   12 multiplications and divisions per sample.
// A sample waits in the output register while m_tready is low; no
// further work starts until it is taken.
// Reset clears the stored keyframe and returns the block to idle.
module rgb_keyframe_fade_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_red[7:0], key_green[15:8], key_blue[23:16], transition_mode[25:24],
    // segment_length[32:26], zero padding [39:33]
    input  logic [39:0] s_tdata,
    // start_new[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    // segment_last
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEQ,
        ST_MUL,
        ST_DIV,
        ST_BLEND,
        ST_EMIT
    } state_t;

    // Steps of the per-sample operation sequence.
    typedef enum logic [3:0] {
        STP_F,
        STP_X,
        STP_X2,
        STP_T1,
        STP_P2,
        STP_T2,
        STP_P3,
        STP_T3,
        STP_P4,
        STP_T4,
        STP_S,
        STP_W,
        STP_L0,
        STP_L1,
        STP_L2,
        STP_NONE
    } step_t;

    localparam int CW = rkfg_pkg::CHAN_W;
    localparam int OW = rkfg_pkg::OP_W;

    state_t                       state_reg;
    step_t                        step_reg;
    logic                         have_prev_reg;
    logic [3*CW-1:0]              prev_color_reg;
    logic [rkfg_pkg::MODE_W-1:0]  prev_mode_reg;
    logic [rkfg_pkg::LEN_W-1:0]   prev_len_reg;
    logic [3*CW-1:0]              seg_c1_reg;
    logic [rkfg_pkg::MODE_W-1:0]  seg_mode_reg;
    logic [rkfg_pkg::LEN_W-1:0]   seg_len_reg;
    logic [rkfg_pkg::IDX_W-1:0]   idx_reg;
    logic [rkfg_pkg::CNT_W-1:0]   op_cnt_reg;

    logic [OW-1:0]                mul_a_reg;
    logic [OW-1:0]                mul_b_reg;
    logic [2*OW-1:0]              mul_acc_reg;
    logic [2*OW-1:0]              mul_acc_next;
    logic [OW:0]                  mul_sum;

    logic [OW-1:0]                div_num_reg;
    logic [OW-1:0]                div_num_next;
    logic [rkfg_pkg::DEN_W-1:0]   div_den_reg;
    logic [rkfg_pkg::DEN_W-1:0]   div_rem_reg;
    logic [rkfg_pkg::DEN_W-1:0]   div_rem_next;
    logic [rkfg_pkg::DEN_W:0]     div_trial;
    logic [rkfg_pkg::DEN_W:0]     div_diff;
    logic                         div_ge;

    logic [OW-1:0]                x_reg;
    logic [OW-1:0]                x2_reg;
    logic [OW-1:0]                t_reg;
    logic [OW-1:0]                val_reg;
    logic [rkfg_pkg::W_W-1:0]     w_reg;
    logic [19:0]                  w_raw;
    logic [rkfg_pkg::W_W-1:0]     w_sat;

    logic [CW-1:0]                out_red_reg;
    logic [CW-1:0]                out_green_reg;
    logic [CW-1:0]                out_blue_reg;

    logic [rkfg_pkg::LEN_W-1:0]   key_len_in;
    logic [rkfg_pkg::LEN_W-1:0]   key_len_sat;
    logic                         key_start_seg;
    logic                         seg_last;
    logic [CW-1:0]                lin_c1;
    logic [CW-1:0]                lin_c2;
    logic [OW-1:0]                lin_dividend;

    // First step of a sample for a given transition mode.
    function automatic step_t first_step(input logic [rkfg_pkg::MODE_W-1:0] mode);
        step_t s;
        case (mode)
            rkfg_pkg::MODE_LINEAR: s = STP_L0;
            rkfg_pkg::MODE_SINE:   s = STP_F;
            default:               s = STP_NONE;
        endcase
        return s;
    endfunction

    // Incoming keyframe length, clipped to the longest segment.
    assign key_len_in  = s_tdata[32:26];
    assign key_len_sat = (key_len_in > rkfg_pkg::MAX_SEGMENT_LENGTH) ?
                         rkfg_pkg::MAX_SEGMENT_LENGTH : key_len_in;
    assign key_start_seg = have_prev_reg && !s_tuser &&
                           (prev_len_reg != '0);

    // One shift-add step of the multiplier, least significant bit first.
    assign mul_sum      = {1'b0, mul_acc_reg[2*OW-1:OW]} +
                          (mul_b_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign mul_acc_next = {mul_sum, mul_acc_reg[OW-1:1]};

    // One restoring step of the divider, most significant bit first.
    assign div_trial    = {div_rem_reg, div_num_reg[OW-1]};
    assign div_diff     = div_trial - {1'b0, div_den_reg};
    assign div_ge       = (div_trial >= {1'b0, div_den_reg});
    assign div_rem_next = div_ge ? div_diff[rkfg_pkg::DEN_W-1:0] :
                                   div_trial[rkfg_pkg::DEN_W-1:0];
    assign div_num_next = {div_num_reg[OW-2:0], div_ge};

    // Saturated Q1.16 weight from the squared sine.
    assign w_raw = mul_acc_next[2*OW-1:44];
    assign w_sat = (w_raw > 20'(rkfg_pkg::W_ONE)) ? rkfg_pkg::W_ONE :
                                                     w_raw[rkfg_pkg::W_W-1:0];

    // Channel operands of the linear blend for the current step.
    always_comb
    begin
        case (step_reg)
            STP_L1:
            begin
                lin_c1 = seg_c1_reg[15:8];
                lin_c2 = prev_color_reg[15:8];
            end
            STP_L2:
            begin
                lin_c1 = seg_c1_reg[7:0];
                lin_c2 = prev_color_reg[7:0];
            end
            default:
            begin
                lin_c1 = seg_c1_reg[23:16];
                lin_c2 = prev_color_reg[23:16];
            end
        endcase
        lin_dividend = OW'(rkfg_pkg::lin_num(lin_c1, lin_c2, idx_reg, seg_len_reg));
    end

    assign seg_last = (({1'b0, idx_reg} + 7'd1) == seg_len_reg);

    // Sequencer, serial arithmetic and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STP_NONE;
            have_prev_reg  <= 1'b0;
            prev_color_reg <= '0;
            prev_mode_reg  <= rkfg_pkg::MODE_NONE;
            prev_len_reg   <= '0;
            seg_c1_reg     <= '0;
            seg_mode_reg   <= rkfg_pkg::MODE_NONE;
            seg_len_reg    <= '0;
            idx_reg        <= '0;
            op_cnt_reg     <= '0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            mul_acc_reg    <= '0;
            div_num_reg    <= '0;
            div_den_reg    <= '0;
            div_rem_reg    <= '0;
            x_reg          <= '0;
            x2_reg         <= '0;
            t_reg          <= '0;
            val_reg        <= '0;
            w_reg          <= '0;
            out_red_reg    <= '0;
            out_green_reg  <= '0;
            out_blue_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                // Take a keyframe; start a segment if one is stored with a nonzero length and start_new is low.
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        seg_c1_reg     <= prev_color_reg;
                        seg_mode_reg   <= prev_mode_reg;
                        seg_len_reg    <= prev_len_reg;
                        idx_reg        <= '0;
                        step_reg       <= first_step(prev_mode_reg);
                        prev_color_reg <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
                        prev_mode_reg  <= s_tdata[25:24];
                        prev_len_reg   <= key_len_sat;
                        have_prev_reg  <= 1'b1;
                        if (key_start_seg)
                        begin
                            state_reg <= ST_SEQ;
                        end
                    end
                end

                // Load the operands of the next operation, or in mode none the output color.
                ST_SEQ:
                begin
                    op_cnt_reg  <= '0;
                    mul_acc_reg <= '0;
                    div_rem_reg <= '0;
                    case (step_reg)
                        STP_F:
                        begin
                            div_num_reg <= {10'd0, idx_reg, 16'd0};
                            div_den_reg <= seg_len_reg;
                            state_reg   <= ST_DIV;
                        end
                        STP_X:
                        begin
                            mul_a_reg <= val_reg;
                            mul_b_reg <= rkfg_pkg::ANGLE_K;
                            state_reg <= ST_MUL;
                        end
                        STP_X2:
                        begin
                            mul_a_reg <= x_reg;
                            mul_b_reg <= x_reg;
                            state_reg <= ST_MUL;
                        end
                        STP_T1:
                        begin
                            div_num_reg <= x2_reg;
                            div_den_reg <= rkfg_pkg::TAYLOR_DIV1;
                            state_reg   <= ST_DIV;
                        end
                        STP_P2, STP_P3, STP_P4:
                        begin
                            mul_a_reg <= x2_reg;
                            mul_b_reg <= t_reg;
                            state_reg <= ST_MUL;
                        end
                        STP_T2:
                        begin
                            div_num_reg <= val_reg;
                            div_den_reg <= rkfg_pkg::TAYLOR_DIV2;
                            state_reg   <= ST_DIV;
                        end
                        STP_T3:
                        begin
                            div_num_reg <= val_reg;
                            div_den_reg <= rkfg_pkg::TAYLOR_DIV3;
                            state_reg   <= ST_DIV;
                        end
                        STP_T4:
                        begin
                            div_num_reg <= val_reg;
                            div_den_reg <= rkfg_pkg::TAYLOR_DIV4;
                            state_reg   <= ST_DIV;
                        end
                        STP_S:
                        begin
                            mul_a_reg <= x_reg;
                            mul_b_reg <= t_reg;
                            state_reg <= ST_MUL;
                        end
                        STP_W:
                        begin
                            mul_a_reg <= val_reg;
                            mul_b_reg <= val_reg;
                            state_reg <= ST_MUL;
                        end
                        STP_L0, STP_L1, STP_L2:
                        begin
                            div_num_reg <= lin_dividend;
                            div_den_reg <= seg_len_reg;
                            state_reg   <= ST_DIV;
                        end
                        default:
                        begin
                            out_red_reg   <= prev_color_reg[23:16];
                            out_green_reg <= prev_color_reg[15:8];
                            out_blue_reg  <= prev_color_reg[7:0];
                            state_reg     <= ST_EMIT;
                        end
                    endcase
                end

                // Multiply one bit per cycle, then store the product, scaled except in step X.
                ST_MUL:
                begin
                    mul_acc_reg <= mul_acc_next;
                    mul_b_reg   <= mul_b_reg >> 1;
                    op_cnt_reg  <= op_cnt_reg + 1'b1;
                    if (op_cnt_reg == rkfg_pkg::OP_LAST)
                    begin
                        case (step_reg)
                            STP_X:
                            begin
                                x_reg     <= mul_acc_next[OW-1:0];
                                step_reg  <= STP_X2;
                                state_reg <= ST_SEQ;
                            end
                            STP_X2:
                            begin
                                x2_reg    <= mul_acc_next[61:30];
                                step_reg  <= STP_T1;
                                state_reg <= ST_SEQ;
                            end
                            STP_P2:
                            begin
                                val_reg   <= mul_acc_next[61:30];
                                step_reg  <= STP_T2;
                                state_reg <= ST_SEQ;
                            end
                            STP_P3:
                            begin
                                val_reg   <= mul_acc_next[61:30];
                                step_reg  <= STP_T3;
                                state_reg <= ST_SEQ;
                            end
                            STP_P4:
                            begin
                                val_reg   <= mul_acc_next[61:30];
                                step_reg  <= STP_T4;
                                state_reg <= ST_SEQ;
                            end
                            STP_S:
                            begin
                                val_reg   <= mul_acc_next[61:30];
                                step_reg  <= STP_W;
                                state_reg <= ST_SEQ;
                            end
                            default:
                            begin
                                w_reg     <= w_sat;
                                state_reg <= ST_BLEND;
                            end
                        endcase
                    end
                end

                // Divide one quotient bit per cycle, then store the result.
                ST_DIV:
                begin
                    div_num_reg <= div_num_next;
                    div_rem_reg <= div_rem_next;
                    op_cnt_reg  <= op_cnt_reg + 1'b1;
                    if (op_cnt_reg == rkfg_pkg::OP_LAST)
                    begin
                        case (step_reg)
                            STP_F:
                            begin
                                val_reg   <= div_num_next;
                                step_reg  <= STP_X;
                                state_reg <= ST_SEQ;
                            end
                            STP_T1:
                            begin
                                t_reg     <= rkfg_pkg::Q30_ONE - div_num_next;
                                step_reg  <= STP_P2;
                                state_reg <= ST_SEQ;
                            end
                            STP_T2:
                            begin
                                t_reg     <= rkfg_pkg::Q30_ONE - div_num_next;
                                step_reg  <= STP_P3;
                                state_reg <= ST_SEQ;
                            end
                            STP_T3:
                            begin
                                t_reg     <= rkfg_pkg::Q30_ONE - div_num_next;
                                step_reg  <= STP_P4;
                                state_reg <= ST_SEQ;
                            end
                            STP_T4:
                            begin
                                t_reg     <= rkfg_pkg::Q30_ONE - div_num_next;
                                step_reg  <= STP_S;
                                state_reg <= ST_SEQ;
                            end
                            STP_L0:
                            begin
                                out_red_reg <= div_num_next[CW-1:0];
                                step_reg    <= STP_L1;
                                state_reg   <= ST_SEQ;
                            end
                            STP_L1:
                            begin
                                out_green_reg <= div_num_next[CW-1:0];
                                step_reg      <= STP_L2;
                                state_reg     <= ST_SEQ;
                            end
                            default:
                            begin
                                out_blue_reg <= div_num_next[CW-1:0];
                                state_reg    <= ST_EMIT;
                            end
                        endcase
                    end
                end

                // Apply the sine-squared weight to all three channels.
                ST_BLEND:
                begin
                    out_red_reg   <= rkfg_pkg::sine_mix(seg_c1_reg[23:16],
                                                        prev_color_reg[23:16], w_reg);
                    out_green_reg <= rkfg_pkg::sine_mix(seg_c1_reg[15:8],
                                                        prev_color_reg[15:8], w_reg);
                    out_blue_reg  <= rkfg_pkg::sine_mix(seg_c1_reg[7:0],
                                                        prev_color_reg[7:0], w_reg);
                    state_reg     <= ST_EMIT;
                end

                // Hold the sample until the transaction completes.
                ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        if (seg_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            step_reg  <= first_step(seg_mode_reg);
                            state_reg <= ST_SEQ;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {out_blue_reg, out_green_reg, out_red_reg};
    assign m_tlast  = seg_last;

endmodule
